/* rtl/core/dwsr_pkg.sv */
package dwsr_pkg;

  localparam int KIND_W   = 2;
  localparam int SEL_W    = 2;
  localparam int TARGET_W = 17;
  localparam int COMMON_W = 16;
  localparam int STEP_W   = 12;
  localparam int IVAL_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WHEELS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MAG    = 2'd2;

  localparam logic [SEL_W-1:0] SEL_RIGHT = 2'd0;
  localparam logic [SEL_W-1:0] SEL_LEFT  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_BOTH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 8'd1;

  localparam logic [STEP_W-1:0] RAMP_STEP_RST     = 12'd13;
  localparam logic [IVAL_W-1:0] STEP_INTERVAL_RST = 16'd20;

  typedef struct packed {
    logic                cmd_signed;
    logic [TARGET_W-1:0] target;
    logic                cmd_mag;
    logic [COMMON_W-1:0] common_speed;
    logic                step_en;
    logic [STEP_W-1:0]   step;
  } lane_ctrl_t;

  typedef struct packed {
    logic forward_nxt;
    logic busy_nxt;
  } lane_stat_t;

endpackage

/* rtl/core/dwsr_lane.sv */
module dwsr_lane #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dwsr_pkg::lane_ctrl_t   ctrl,
  output logic [SPEED_WIDTH-1:0] speed_nxt,
  output dwsr_pkg::lane_stat_t   stat
);
  import dwsr_pkg::*;

  localparam int AW = (SPEED_WIDTH > STEP_W ? SPEED_WIDTH : STEP_W) + 1;
  localparam int SW33 = 33;

  logic [SPEED_WIDTH-1:0] sp_r, sp_nxt;
  logic [SPEED_WIDTH-1:0] goal_r, goal_nxt;
  logic                   dir_r, dir_nxt;
  logic                   pend_r, pend_nxt;

  logic                   fwd;
  logic [TARGET_W-1:0]    neg_target;
  logic [TARGET_W-1:0]    mag;
  logic [SW33-1:0]        mag33, com33, max33;
  logic [SPEED_WIDTH-1:0] goal_cmd, goal_com;

  logic [SPEED_WIDTH-1:0] eff;
  logic [AW-1:0]          sp_ext, eff_ext, step_ext, sum, diff, sub;
  logic [SPEED_WIDTH-1:0] sp_step;

  // magnitude and direction of a signed command
  assign fwd        = ~ctrl.target[TARGET_W-1];
  assign neg_target = ~ctrl.target + {{(TARGET_W-1){1'b0}}, 1'b1};
  assign mag        = fwd ? ctrl.target : neg_target;

  assign mag33 = {{(SW33-TARGET_W){1'b0}}, mag};
  assign com33 = {{(SW33-COMMON_W){1'b0}}, ctrl.common_speed};
  assign max33 = {{(SW33-SPEED_WIDTH){1'b0}}, {SPEED_WIDTH{1'b1}}};

  assign goal_cmd = (mag33 > max33) ? {SPEED_WIDTH{1'b1}} : mag33[SPEED_WIDTH-1:0];
  assign goal_com = (com33 > max33) ? {SPEED_WIDTH{1'b1}} : com33[SPEED_WIDTH-1:0];

  // one ramp step toward the effective goal
  assign eff      = pend_r ? '0 : goal_r;
  assign sp_ext   = {{(AW-SPEED_WIDTH){1'b0}}, sp_r};
  assign eff_ext  = {{(AW-SPEED_WIDTH){1'b0}}, eff};
  assign step_ext = {{(AW-STEP_W){1'b0}}, ctrl.step};
  assign sum      = sp_ext + step_ext;
  assign diff     = sp_ext - eff_ext;
  assign sub      = sp_ext - step_ext;

  always_comb begin
    if (sp_r < eff) begin
      sp_step = (sum > eff_ext) ? eff : sum[SPEED_WIDTH-1:0];
    end else if (sp_r > eff) begin
      sp_step = (diff > step_ext) ? sub[SPEED_WIDTH-1:0] : eff;
    end else begin
      sp_step = sp_r;
    end
  end

  always_comb begin
    sp_nxt   = sp_r;
    goal_nxt = goal_r;
    dir_nxt  = dir_r;
    pend_nxt = pend_r;
    if (ctrl.cmd_signed) begin
      goal_nxt = goal_cmd;
      pend_nxt = pend_r | (fwd != dir_r);
    end else if (ctrl.cmd_mag) begin
      goal_nxt = goal_com;
    end else if (ctrl.step_en) begin
      sp_nxt = sp_step;
    end
    // reversal completes once the wheel is stopped
    if ((ctrl.cmd_signed || ctrl.step_en) && pend_nxt && (sp_nxt == '0)) begin
      dir_nxt  = ~dir_r;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      goal_r <= '0;
      dir_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      sp_r   <= sp_nxt;
      goal_r <= goal_nxt;
      dir_r  <= dir_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign speed_nxt        = sp_nxt;
  assign stat.forward_nxt = dir_nxt;
  assign stat.busy_nxt    = pend_nxt | (sp_nxt != (pend_nxt ? '0 : goal_nxt));

endmodule

/* rtl/core/dual_wheel_speed_ramp.sv */
// Two-wheel speed setpoint ramp. Each input word is a timer tick or a command and
// gives exactly one result word with both setpoints, directions, busy and reject
// flags. A word is taken every clock cycle unless the output register is stalled:
// both wheel lanes compute their next setpoint in the same cycle (one add, compare
// and clamp each) and the result is held in a single output register, which frees
// itself in the cycle it is taken. Commands that arrive while a ramp is in progress
// are rejected unchanged. Configuration is one register write per cycle: index 0 is
// the ramp step, index 1 the number of ticks between steps.
module dual_wheel_speed_ramp #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // right_target, left_target, common_speed, zero pad
  input  logic [55:0] in_tdata,
  // kind, motor_select
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // right_speed, left_speed, right_forward, left_forward, busy_res, rejected, zero pad
  output logic [((2*SPEED_WIDTH+4+7)/8)*8-1:0] out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dwsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dwsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dwsr_pkg::*;

  localparam int RES_W = 2*SPEED_WIDTH + 4;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  logic [STEP_W-1:0] ramp_step_r;
  logic [IVAL_W-1:0] step_interval_r;
  logic [IVAL_W-1:0] tick_r, tick_nxt;
  logic              ramping_r, ramping_nxt;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic                accept;
  logic [KIND_W-1:0]   kind;
  logic [SEL_W-1:0]    sel;
  logic                is_cmd, is_tick, cmd_take, tick_hit, rej;
  logic [IVAL_W-1:0]   ival;
  logic [IVAL_W:0]     tick_inc;
  logic [STEP_W-1:0]   step_eff;

  lane_ctrl_t             r_ctrl, l_ctrl;
  lane_stat_t             r_stat, l_stat;
  logic [SPEED_WIDTH-1:0] r_speed, l_speed;
  logic [RES_W-1:0]       result;

  assign kind      = in_tuser[1:0];
  assign sel       = in_tuser[3:2];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign is_tick  = (kind == KIND_TICK);
  assign is_cmd   = (kind == KIND_WHEELS) || (kind == KIND_MAG);
  assign rej      = is_cmd && ramping_r;
  assign ival     = (step_interval_r == '0) ? {{(IVAL_W-1){1'b0}}, 1'b1} : step_interval_r;
  assign tick_inc = {1'b0, tick_r} + {{IVAL_W{1'b0}}, 1'b1};
  assign tick_hit = tick_inc >= {1'b0, ival};
  assign step_eff = (ramp_step_r == '0) ? {{(STEP_W-1){1'b0}}, 1'b1} : ramp_step_r;
  assign cmd_take = accept && !ramping_r &&
                    ((kind == KIND_WHEELS) ||
                     ((kind == KIND_MAG) && (sel inside {SEL_RIGHT, SEL_LEFT, SEL_BOTH})));

  // lane controls
  always_comb begin
    r_ctrl.cmd_signed   = accept && !ramping_r && (kind == KIND_WHEELS);
    r_ctrl.target       = in_tdata[16:0];
    r_ctrl.cmd_mag      = accept && !ramping_r && (kind == KIND_MAG) &&
                          (sel inside {SEL_RIGHT, SEL_BOTH});
    r_ctrl.common_speed = in_tdata[49:34];
    r_ctrl.step_en      = accept && is_tick && ramping_r && tick_hit;
    r_ctrl.step         = step_eff;
    l_ctrl              = r_ctrl;
    l_ctrl.target       = in_tdata[33:17];
    l_ctrl.cmd_mag      = accept && !ramping_r && (kind == KIND_MAG) &&
                          (sel inside {SEL_LEFT, SEL_BOTH});
  end

  dwsr_lane #(.SPEED_WIDTH(SPEED_WIDTH)) u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (r_ctrl),
    .speed_nxt (r_speed),
    .stat      (r_stat)
  );

  dwsr_lane #(.SPEED_WIDTH(SPEED_WIDTH)) u_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (l_ctrl),
    .speed_nxt (l_speed),
    .stat      (l_stat)
  );

  // merge lanes
  always_comb begin
    ramping_nxt = ramping_r;
    tick_nxt    = tick_r;
    if (accept) begin
      ramping_nxt = r_stat.busy_nxt || l_stat.busy_nxt;
      if (is_tick && ramping_r) begin
        tick_nxt = tick_hit ? '0 : tick_inc[IVAL_W-1:0];
      end else if (cmd_take) begin
        tick_nxt = '0;
      end
    end
  end

  assign result = {rej, ramping_nxt, l_stat.forward_nxt, r_stat.forward_nxt, l_speed, r_speed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r     <= RAMP_STEP_RST;
      step_interval_r <= STEP_INTERVAL_RST;
      tick_r          <= '0;
      ramping_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      tick_r    <= tick_nxt;
      ramping_r <= ramping_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RAMP_STEP:     ramp_step_r     <= cfg_data[STEP_W-1:0];
          CFG_STEP_INTERVAL: step_interval_r <= cfg_data[IVAL_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {{(OUT_W-RES_W){1'b0}}, result};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
